FILE: rtl/ss_pkg.sv
// Shared constants, item type and codes for the stride scheduler.
package ss_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int IDX_W       = $clog2(NUM_SLOTS);
  localparam int SLOT_W      = 3;
  localparam int PRIO_W      = 8;
  localparam int QUANTA_W    = 16;
  localparam int STRIDE_W    = 17;
  localparam int PASS_W      = 32;

  // Stride numerator: 1.0 in Q1.16 fixed point.
  localparam logic [STRIDE_W-1:0] STRIDE_ONE = STRIDE_W'(65536);
  localparam int DIV_STEPS   = STRIDE_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [SLOT_W-1:0]   slot;
    logic [PRIO_W-1:0]   prio;
    logic [QUANTA_W-1:0] quanta;
    logic [STRIDE_W-1:0] stride;
  } ss_item_t;

  typedef struct packed {
    logic     valid;
    ss_item_t item;
  } ss_queue_out_t;

endpackage

FILE: rtl/stride_scheduler.sv
// A tick is served by a serial scan over all NUM_SLOTS slots in the back end (8-slot scan).
// A load is held in the front end while the 17-step stride divider forms its stride.
// The back end finishes one tick before it takes the next item; the front takes no item while dividing.
// The two-entry queue lets the front accept while the back scans or the output stalls.
// Reset (synchronous, rst high) clears the slot table, the queue and all handshakes.
module stride_scheduler import ss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [PRIO_W-1:0]   priority_req,
  input  logic [QUANTA_W-1:0] quanta,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   chosen_slot,
  output logic                none_ready
);

  logic          push;
  ss_item_t      push_item;
  logic          q_full;
  logic          pop;
  ss_queue_out_t head;

  ss_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .slot         (slot),
    .priority_req (priority_req),
    .quanta       (quanta),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  ss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  ss_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .chosen_slot (chosen_slot),
    .none_ready  (none_ready)
  );

endmodule

FILE: rtl/ss_div.sv
// Restoring divider that forms the stride, one quotient bit per cycle.
module ss_div import ss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PRIO_W-1:0]   divisor,
  output logic                busy,
  output logic [STRIDE_W-1:0] quot
);

  logic [STRIDE_W-1:0]  work;
  logic [PRIO_W-1:0]    rem;
  logic [PRIO_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PRIO_W:0]      rem_sh;
  logic [PRIO_W:0]      diff;
  logic                 ge;

  assign rem_sh = {rem, work[STRIDE_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};
  assign quot   = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // A zero divisor always subtracts, so the quotient saturates to all ones.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= STRIDE_ONE;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[STRIDE_W-2:0], ge};
      rem  <= ge ? diff[PRIO_W-1:0] : rem_sh[PRIO_W-1:0];
    end
  end

endmodule

FILE: rtl/ss_front.sv
// Front end: accepts items, computes the stride of a load, pushes to the queue.
module ss_front import ss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [PRIO_W-1:0]   priority_req,
  input  logic [QUANTA_W-1:0] quanta,
  input  logic                q_full,
  output logic                push,
  output ss_item_t            push_item
);

  logic                hold_valid;
  logic                hold_type;
  logic [SLOT_W-1:0]   hold_slot;
  logic [PRIO_W-1:0]   hold_prio;
  logic [QUANTA_W-1:0] hold_quanta;
  logic                accept;
  logic                div_start;
  logic                div_busy;
  logic [STRIDE_W-1:0] div_quot;

  assign push      = hold_valid && !div_busy && !q_full;
  assign in_stall  = hold_valid && !push;
  assign accept    = in_valid && !in_stall;
  assign div_start = accept && (req_type == REQ_LOAD);

  ss_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (priority_req),
    .busy    (div_busy),
    .quot    (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_type   <= req_type;
      hold_slot   <= slot;
      hold_prio   <= priority_req;
      hold_quanta <= quanta;
    end
  end

  always_comb begin
    push_item.req_type = hold_type;
    push_item.slot     = hold_slot;
    push_item.prio     = hold_prio;
    push_item.quanta   = hold_quanta;
    push_item.stride   = div_quot;
  end

endmodule

FILE: rtl/ss_queue.sv
// Short FIFO between front and back ends.
module ss_queue import ss_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ss_item_t      push_item,
  output logic          full,
  input  logic          pop,
  output ss_queue_out_t head
);

  ss_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/ss_back.sv
// Back end: slot table, serial minimum-pass scan and the result register.
module ss_back import ss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ss_queue_out_t       head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   chosen_slot,
  output logic                none_ready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [PASS_W-1:0]   pass_value    [NUM_SLOTS];
  logic [STRIDE_W-1:0] stride_value  [NUM_SLOTS];
  logic [PRIO_W-1:0]   slot_priority [NUM_SLOTS];
  logic [QUANTA_W-1:0] quanta_left   [NUM_SLOTS];

  logic [1:0]          state;
  logic [IDX_W-1:0]    scan_idx;
  logic                found;
  logic [IDX_W-1:0]    best_idx;
  logic [PASS_W-1:0]   best_pass;
  logic [STRIDE_W-1:0] best_stride;
  logic [PRIO_W-1:0]   best_prio;
  logic [QUANTA_W-1:0] best_quanta;

  logic                cand_active;
  logic                cand_beats;
  logic                take;
  logic                scan_last;
  logic                load_hit;
  logic                out_free;
  logic [PASS_W:0]     pass_sum;
  logic [PASS_W-1:0]   pass_next;
  logic [IDX_W-1:0]    load_idx;

  assign out_free    = !out_valid || !out_stall;
  assign pop         = (state == ST_IDLE) && head.valid;
  assign load_idx    = IDX_W'(head.item.slot);
  assign load_hit    = pop && (head.item.req_type == REQ_LOAD)
                       && (int'(head.item.slot) < NUM_SLOTS);

  assign cand_active = quanta_left[scan_idx] != '0;
  assign cand_beats  = !found
                       || (pass_value[scan_idx] < best_pass)
                       || ((pass_value[scan_idx] == best_pass)
                           && (slot_priority[scan_idx] > best_prio));
  assign take        = cand_active && cand_beats;
  assign scan_last   = scan_idx == IDX_W'(NUM_SLOTS - 1);

  // Saturate the pass on overflow.
  assign pass_sum  = {1'b0, best_pass} + (PASS_W + 1)'(best_stride);
  assign pass_next = pass_sum[PASS_W] ? '1 : pass_sum[PASS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      found     <= 1'b0;
      scan_idx  <= '0;
    end else begin
      if ((state == ST_UPDATE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop && (head.item.req_type == REQ_TICK)) begin
            found    <= 1'b0;
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (take) begin
            found <= 1'b1;
          end
          if (scan_last) begin
            state <= ST_UPDATE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && take) begin
      best_idx    <= scan_idx;
      best_pass   <= pass_value[scan_idx];
      best_stride <= stride_value[scan_idx];
      best_prio   <= slot_priority[scan_idx];
      best_quanta <= quanta_left[scan_idx];
    end
    if ((state == ST_UPDATE) && out_free) begin
      chosen_slot <= found ? SLOT_W'(best_idx) : '0;
      none_ready  <= !found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        pass_value[i]    <= '0;
        stride_value[i]  <= '0;
        slot_priority[i] <= '0;
        quanta_left[i]   <= '0;
      end
    end else if (load_hit) begin
      pass_value[load_idx]    <= '0;
      stride_value[load_idx]  <= head.item.stride;
      slot_priority[load_idx] <= head.item.prio;
      quanta_left[load_idx]   <= head.item.quanta;
    end else if ((state == ST_UPDATE) && out_free && found) begin
      pass_value[best_idx]  <= pass_next;
      quanta_left[best_idx] <= best_quanta - 1'b1;
    end
  end

endmodule

FILE: rtl/ss_checker.sv
// Port-level assertions for the stride scheduler, bound to the top level.
module ss_checker import ss_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                req_type,
  input logic                out_valid,
  input logic                out_stall,
  input logic [SLOT_W-1:0]   chosen_slot,
  input logic                none_ready
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chosen_slot) && $stable(none_ready))
    else $error("stalled result changed");

  a_none_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_ready |-> chosen_slot == '0)
    else $error("none_ready with nonzero slot");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A load occupies the divider, so the front stalls in the next cycle.
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == REQ_LOAD) |=> in_stall)
    else $error("front took an item while dividing");

endmodule

bind stride_scheduler ss_checker u_ss_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .req_type    (req_type),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .chosen_slot (chosen_slot),
  .none_ready  (none_ready)
);

FILE: tb/tb_stride_scheduler.sv
// Self-checking testbench for the stride scheduler: directed and random load and tick items.
module tb_stride_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import ss_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              none;
  } grant_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                req_type;
  logic [SLOT_W-1:0]   slot;
  logic [PRIO_W-1:0]   priority_req;
  logic [QUANTA_W-1:0] quanta;
  logic                out_valid;
  logic                out_stall;
  logic [SLOT_W-1:0]   chosen_slot;
  logic                none_ready;

  // Scheduler table as the block should hold it
  logic [PASS_W-1:0]   sched_pass   [NUM_SLOTS];
  logic [STRIDE_W-1:0] sched_stride [NUM_SLOTS];
  logic [PRIO_W-1:0]   sched_prio   [NUM_SLOTS];
  logic [QUANTA_W-1:0] sched_left   [NUM_SLOTS];

  grant_t grant_q[$];
  int     mismatches = 0;
  bit     no_idle = 1'b0;

  stride_scheduler uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .slot         (slot),
    .priority_req (priority_req),
    .quanta       (quanta),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen_slot  (chosen_slot),
    .none_ready   (none_ready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 9);
  endfunction

  // Apply one accepted item to the table and queue the grant a tick produces.
  function automatic void predict_item(input logic kind, input logic [SLOT_W-1:0] s,
                                       input logic [PRIO_W-1:0] p,
                                       input logic [QUANTA_W-1:0] q);
    int            best;
    logic [PASS_W:0] sum;
    grant_t        g;
    if (kind == REQ_LOAD) begin
      if (int'(s) < NUM_SLOTS) begin
        sched_prio[s]   = p;
        sched_left[s]   = q;
        sched_pass[s]   = '0;
        sched_stride[s] = (p == 0) ? '1 : STRIDE_W'(65536 / int'(p));
      end
      return;
    end
    best = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sched_left[i] == 0) continue;
      // Lowest pass wins, then higher priority; scan order keeps the lower index
      if (best < 0 || sched_pass[i] < sched_pass[best] ||
          (sched_pass[i] == sched_pass[best] && sched_prio[i] > sched_prio[best]))
        best = i;
    end
    if (best < 0) begin
      g.slot = '0;
      g.none = 1'b1;
    end else begin
      sum = {1'b0, sched_pass[best]} + sched_stride[best];
      sched_pass[best] = sum[PASS_W] ? '1 : sum[PASS_W-1:0];
      sched_left[best] = sched_left[best] - 1'b1;
      g.slot = SLOT_W'(best);
      g.none = 1'b0;
    end
    grant_q.push_back(g);
  endfunction

  task automatic send_item(input logic kind, input logic [SLOT_W-1:0] s,
                           input logic [PRIO_W-1:0] p, input logic [QUANTA_W-1:0] q);
    int gap;
    gap = draw_wait();
    // Keep valid high across back-to-back items; drop it only for a real gap
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    slot         <= s;
    priority_req <= p;
    quanta       <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(kind, s, p, q);
  endtask

  task automatic load_slot(input logic [SLOT_W-1:0] s, input logic [PRIO_W-1:0] p,
                           input logic [QUANTA_W-1:0] q);
    send_item(REQ_LOAD, s, p, q);
  endtask

  // Unused fields of a tick carry random junk
  task automatic tick();
    send_item(REQ_TICK, SLOT_W'($urandom), PRIO_W'($urandom), QUANTA_W'($urandom));
  endtask

  // Deactivate every slot that still owes quanta.
  task automatic clear_table();
    for (int i = 0; i < NUM_SLOTS; i++)
      if (sched_left[i] != 0) load_slot(SLOT_W'(i), PRIO_W'($urandom), '0);
  endtask

  task automatic test_empty_table();
    send_item(REQ_TICK, '1, '1, '1);
    send_item(REQ_TICK, '0, '0, '0);
  endtask

  task automatic test_tie_breaks();
    load_slot(3'd7, 8'd255, 16'd2);
    load_slot(3'd3, 8'd255, 16'd2);
    load_slot(3'd5, 8'd1, 16'd1);
    repeat (3) tick();
  endtask

  task automatic test_stride_extremes();
    load_slot(3'd0, 8'd0, 16'hFFFF);
    load_slot(3'd6, 8'd128, 16'd3);
    repeat (4) tick();
  endtask

  task automatic test_zero_quanta();
    load_slot(3'd4, 8'hAA, 16'd0);
    tick();
    clear_table();
    tick();
  endtask

  task automatic test_random_mix(input int count);
    logic [PRIO_W-1:0]   p;
    logic [QUANTA_W-1:0] q;
    for (int k = 0; k < count; k++) begin
      if (k % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (k % 100 == 99) begin
        clear_table();
      end else if ($urandom_range(0, 99) < 35) begin
        case ($urandom_range(0, 7))
          0:       p = '0;
          1:       p = 8'd1;
          2:       p = '1;
          default: p = PRIO_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0:       q = '0;
          1:       q = QUANTA_W'($urandom);
          2:       q = '1;
          default: q = QUANTA_W'($urandom_range(1, 6));
        endcase
        load_slot(SLOT_W'($urandom), p, q);
      end else begin
        tick();
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver: stall a random number of cycles ahead of each result
  initial begin : drive_out_stall
    int hold;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_grant
    grant_t want;
    if (!rst && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result: chosen_slot=%0d none_ready=%0b", chosen_slot, none_ready);
        mismatches++;
      end else begin
        want = grant_q.pop_front();
        if (chosen_slot !== want.slot) begin
          $error("chosen_slot: expected %0d, got %0d", want.slot, chosen_slot);
          mismatches++;
        end
        if (none_ready !== want.none) begin
          $error("none_ready: expected %0b, got %0b", want.none, none_ready);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    req_type     <= REQ_LOAD;
    slot         <= '0;
    priority_req <= '0;
    quanta       <= '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sched_pass[i]   = '0;
      sched_stride[i] = '0;
      sched_prio[i]   = '0;
      sched_left[i]   = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_tie_breaks();
    test_stride_extremes();
    test_zero_quanta();
    test_random_mix(550);

    // Drop valid right at the last accepting edge so no item goes in twice
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #3ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
